/* hw/rtl/acit_pkg.sv */
// ----------------------------------------------------------------------------
// acit_pkg
// Shared types, codes and constants of the in-flight command tracker.
// ----------------------------------------------------------------------------
package acit_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
  localparam int unsigned RES_CAP             = 16;

  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned MT_W    = 4;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned REM_W   = 13;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned REQ_W   = 2;

  localparam int unsigned S_TDATA_W = 88;
  localparam int unsigned S_TUSER_W = REQ_W;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = KIND_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = ID_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_ID = 1'd0,
    REG_CTRL_EN  = 1'd1
  } reg_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_ISSUE = 2'd0,
    REQ_RX    = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ISSUED    = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_NOT_CTRL  = 3'd2,
    KIND_RETX      = 3'd3,
    KIND_COMPLETED = 3'd4,
    KIND_TIMED_OUT = 3'd5,
    KIND_SNIFF_RSP = 3'd6,
    KIND_SNIFF_CMD = 3'd7
  } kind_e;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [MT_W-1:0]  mtype;
    logic [REM_W-1:0] rem;
    logic             retried;
  } entry_t;

  function automatic logic [REM_W-1:0] timeout_ms(input logic [MT_W-1:0] t);
    logic [REM_W-1:0] r;
    case (t)
      4'd0:    r = 13'd2000;
      4'd2:    r = 13'd200;
      4'd4:    r = 13'd200;
      4'd6:    r = 13'd4500;
      4'd8:    r = 13'd500;
      4'd10:   r = 13'd200;
      4'd12:   r = 13'd200;
      default: r = 13'd250;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/acit_entry_ram.sv */
// ----------------------------------------------------------------------------
// acit_entry_ram
// Entry table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module acit_entry_ram #(
  parameter int unsigned DEPTH = acit_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  acit_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output acit_pkg::entry_t rdata_o
);
  import acit_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/acmp_inflight_command_tracker_top.sv */
// ----------------------------------------------------------------------------
// acmp_inflight_command_tracker_top
// Tracks in-flight connection-management commands in an entry table.
//
//   Channel  Dir  Handshake                  Contents
//   s_axis   in   s_axis_tvalid/tready       request word: kind in tuser
//   m_axis   out  m_axis_tvalid/tready       result word: kind in tuser, tlast
//   cfg      in   cfg_we_i                   controller id, enable bit
//
// Issue, receive and tick words scan the table one entry per cycle through
// the single read port of the entry memory, unless a tick scan is stalled.
// An issue word while the controller is disabled skips the scan. A result
// word held by a low m_axis_tready stalls a tick scan at an expiry met while
// another is pending, and holds the final step of any word with a result.
// Reset clears the valid bits at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module acmp_inflight_command_tracker_top #(
  parameter int unsigned TABLE_DEPTH = acit_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // msg_type[3:0], rx_controller_id[67:4], rx_sequence[83:68], zero fill
  input  logic [acit_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // req_type[1:0]
  input  logic [acit_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sequence_res[15:0], cmd_type[19:16], zero fill
  output logic [acit_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // result_kind[2:0]
  output logic [acit_pkg::M_TUSER_W-1:0]     m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [acit_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [acit_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import acit_pkg::*;

  localparam int unsigned IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned NCW = $clog2(RES_CAP + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  req_e                op_q, op_d;
  logic                noctl_q, noctl_d;
  logic [MT_W-1:0]     mt_q, mt_d;
  logic [SEQ_W-1:0]    key_q, key_d;
  logic                rx_ok_q, rx_ok_d;
  logic [SEQ_W-1:0]    seq_ctr_q, seq_ctr_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic                p_vld_q, p_vld_d;
  logic [IW-1:0]       p_idx_q, p_idx_d;
  logic                found_q, found_d;
  logic [IW-1:0]       fidx_q, fidx_d;
  logic                tmatch_q, tmatch_d;
  logic                free_q, free_d;
  logic [IW-1:0]       free_idx_q, free_idx_d;
  logic [NCW-1:0]      n_q, n_d;
  logic                h_vld_q, h_vld_d;
  kind_e               h_kind_q, h_kind_d;
  logic [SEQ_W-1:0]    h_seq_q, h_seq_d;
  logic [MT_W-1:0]     h_type_q, h_type_d;
  logic                o_vld_q, o_vld_d;
  kind_e               o_kind_q, o_kind_d;
  logic [SEQ_W-1:0]    o_seq_q, o_seq_d;
  logic [MT_W-1:0]     o_type_q, o_type_d;
  logic                o_last_q, o_last_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [ID_W-1:0]     local_id_q, local_id_d;
  logic                ctrl_en_q, ctrl_en_d;

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_wdata, ram_rdata, rd_e;
  logic                o_free, ent_v, seq_hit, expired, p_stall;
  logic                fin_vld;
  kind_e               fin_kind;
  logic [SEQ_W-1:0]    fin_seq, fin_type_seq;
  logic [MT_W-1:0]     in_mt;
  logic [ID_W-1:0]     in_id;
  logic [SEQ_W-1:0]    in_seq, next_seq;

  assign in_mt  = s_axis_tdata[MT_W-1:0];
  assign in_id  = s_axis_tdata[MT_W+ID_W-1:MT_W];
  assign in_seq = s_axis_tdata[MT_W+ID_W+SEQ_W-1:MT_W+ID_W];

  assign next_seq = (seq_ctr_q == {SEQ_W{1'b1}}) ? SEQ_W'(1) : seq_ctr_q + SEQ_W'(1);

  assign rd_e    = ram_rdata;
  assign ent_v   = valid_q[p_idx_q];
  assign seq_hit = ent_v && (rd_e.seq == key_q);
  assign expired = ent_v && (rd_e.rem == '0) && (n_q < NCW'(RES_CAP));
  assign o_free  = !o_vld_q || m_axis_tready;
  assign p_stall = p_vld_q && (op_q == REQ_TICK) && expired && h_vld_q && !o_free;

  assign fin_type_seq = key_q;

  always_comb begin
    fin_vld  = 1'b1;
    fin_kind = KIND_NOT_CTRL;
    fin_seq  = key_q;
    if (noctl_q) begin
      fin_kind = KIND_NOT_CTRL;
      fin_seq  = '0;
    end else begin
      case (op_q)
        REQ_ISSUE: fin_kind = (found_q || free_q) ? KIND_ISSUED : KIND_FULL;
        REQ_RX: begin
          if (found_q && tmatch_q) begin
            fin_kind = KIND_COMPLETED;
          end else begin
            fin_kind = mt_q[0] ? KIND_SNIFF_RSP : KIND_SNIFF_CMD;
          end
        end
        REQ_TICK: begin
          fin_vld  = h_vld_q;
          fin_kind = h_kind_q;
          fin_seq  = h_seq_q;
        end
        default: fin_vld = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    noctl_d    = noctl_q;
    mt_d       = mt_q;
    key_d      = key_q;
    rx_ok_d    = rx_ok_q;
    seq_ctr_d  = seq_ctr_q;
    rd_idx_d   = rd_idx_q;
    p_vld_d    = p_vld_q;
    p_idx_d    = p_idx_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    tmatch_d   = tmatch_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    n_d        = n_q;
    h_vld_d    = h_vld_q;
    h_kind_d   = h_kind_q;
    h_seq_d    = h_seq_q;
    h_type_d   = h_type_q;
    o_vld_d    = o_vld_q;
    o_kind_d   = o_kind_q;
    o_seq_d    = o_seq_q;
    o_type_d   = o_type_q;
    o_last_d   = o_last_q;
    valid_d    = valid_q;
    local_id_d = local_id_q;
    ctrl_en_d  = ctrl_en_q;
    ram_we     = 1'b0;
    ram_waddr  = p_idx_q;
    ram_wdata  = rd_e;
    ram_re     = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCAL_ID: local_id_d = cfg_wdata_i;
        REG_CTRL_EN:  ctrl_en_d  = cfg_wdata_i[0];
        default:      ;
      endcase
    end

    if (o_vld_q && m_axis_tready) begin
      o_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mt_d     = in_mt;
          noctl_d  = 1'b0;
          rd_idx_d = '0;
          p_vld_d  = 1'b0;
          found_d  = 1'b0;
          free_d   = 1'b0;
          tmatch_d = 1'b0;
          n_d      = '0;
          h_vld_d  = 1'b0;
          case (s_axis_tuser)
            REQ_ISSUE: begin
              op_d = REQ_ISSUE;
              if (!ctrl_en_q) begin
                noctl_d = 1'b1;
                state_d = ST_FINISH;
              end else begin
                seq_ctr_d = next_seq;
                key_d     = next_seq;
                state_d   = ST_SCAN;
              end
            end
            REQ_RX: begin
              op_d    = REQ_RX;
              key_d   = in_seq;
              rx_ok_d = in_mt[0] && (in_id == local_id_q);
              state_d = ST_SCAN;
            end
            REQ_TICK: begin
              op_d    = REQ_TICK;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (p_vld_q && !p_stall) begin
          case (op_q)
            REQ_ISSUE: begin
              if (seq_hit && !found_q) begin
                found_d = 1'b1;
                fidx_d  = p_idx_q;
              end
              if (!ent_v && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = p_idx_q;
              end
            end
            REQ_RX: begin
              if (seq_hit && !found_q && rx_ok_q) begin
                found_d  = 1'b1;
                fidx_d   = p_idx_q;
                tmatch_d = ({1'b0, rd_e.mtype} + 5'd1) == {1'b0, mt_q};
              end
            end
            REQ_TICK: begin
              if (ent_v && (rd_e.rem != '0)) begin
                ram_we        = 1'b1;
                ram_wdata.rem = rd_e.rem - REM_W'(1);
              end else if (expired) begin
                n_d = n_q + NCW'(1);
                if (!rd_e.retried) begin
                  ram_we            = 1'b1;
                  ram_wdata.rem     = timeout_ms(rd_e.mtype);
                  ram_wdata.retried = 1'b1;
                  h_kind_d          = KIND_RETX;
                end else begin
                  valid_d[p_idx_q] = 1'b0;
                  h_kind_d         = KIND_TIMED_OUT;
                end
                h_vld_d  = 1'b1;
                h_seq_d  = rd_e.seq;
                h_type_d = rd_e.mtype;
                if (h_vld_q) begin
                  o_vld_d  = 1'b1;
                  o_kind_d = h_kind_q;
                  o_seq_d  = h_seq_q;
                  o_type_d = h_type_q;
                  o_last_d = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        if (!p_stall) begin
          if (rd_idx_q != CW'(TABLE_DEPTH)) begin
            ram_re   = 1'b1;
            p_vld_d  = 1'b1;
            p_idx_d  = rd_idx_q[IW-1:0];
            rd_idx_d = rd_idx_q + CW'(1);
          end else begin
            p_vld_d = 1'b0;
            if (!p_vld_q) begin
              state_d = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        if (!fin_vld) begin
          state_d = ST_IDLE;
        end else if (o_free) begin
          o_vld_d  = 1'b1;
          o_kind_d = fin_kind;
          o_seq_d  = fin_seq;
          o_type_d = (op_q == REQ_TICK && !noctl_q) ? h_type_q : mt_q;
          o_last_d = 1'b1;
          h_vld_d  = 1'b0;
          state_d  = ST_IDLE;
          if (!noctl_q && op_q == REQ_ISSUE && (found_q || free_q)) begin
            ram_we            = 1'b1;
            ram_waddr         = found_q ? fidx_q : free_idx_q;
            ram_wdata.seq     = fin_type_seq;
            ram_wdata.mtype   = mt_q;
            ram_wdata.rem     = timeout_ms(mt_q);
            ram_wdata.retried = 1'b0;
            valid_d[ram_waddr] = 1'b1;
          end
          if (op_q == REQ_RX && found_q && tmatch_q) begin
            valid_d[fidx_q] = 1'b0;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= REQ_NONE;
      noctl_q    <= 1'b0;
      mt_q       <= '0;
      key_q      <= '0;
      rx_ok_q    <= 1'b0;
      seq_ctr_q  <= '0;
      rd_idx_q   <= '0;
      p_vld_q    <= 1'b0;
      p_idx_q    <= '0;
      found_q    <= 1'b0;
      fidx_q     <= '0;
      tmatch_q   <= 1'b0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      n_q        <= '0;
      h_vld_q    <= 1'b0;
      h_kind_q   <= KIND_ISSUED;
      h_seq_q    <= '0;
      h_type_q   <= '0;
      o_vld_q    <= 1'b0;
      o_kind_q   <= KIND_ISSUED;
      o_seq_q    <= '0;
      o_type_q   <= '0;
      o_last_q   <= 1'b0;
      valid_q    <= '0;
      local_id_q <= '0;
      ctrl_en_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      noctl_q    <= noctl_d;
      mt_q       <= mt_d;
      key_q      <= key_d;
      rx_ok_q    <= rx_ok_d;
      seq_ctr_q  <= seq_ctr_d;
      rd_idx_q   <= rd_idx_d;
      p_vld_q    <= p_vld_d;
      p_idx_q    <= p_idx_d;
      found_q    <= found_d;
      fidx_q     <= fidx_d;
      tmatch_q   <= tmatch_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      n_q        <= n_d;
      h_vld_q    <= h_vld_d;
      h_kind_q   <= h_kind_d;
      h_seq_q    <= h_seq_d;
      h_type_q   <= h_type_d;
      o_vld_q    <= o_vld_d;
      o_kind_q   <= o_kind_d;
      o_seq_q    <= o_seq_d;
      o_type_q   <= o_type_d;
      o_last_q   <= o_last_d;
      valid_q    <= valid_d;
      local_id_q <= local_id_d;
      ctrl_en_q  <= ctrl_en_d;
    end
  end

  acit_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {{(M_TDATA_W - SEQ_W - MT_W){1'b0}}, o_type_q, o_seq_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

endmodule

/* hw/rtl/acit_checker.sv */
// ----------------------------------------------------------------------------
// acit_port_checker
// Port-level checks of the command tracker, bound to the top level.
// ----------------------------------------------------------------------------
module acit_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [acit_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [acit_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [acit_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  input logic                            m_axis_tlast
);
  import acit_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_NONE) |=> !s_axis_tready)
    else $error("request word accepted while a scan should be running");

  a_seq_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_ISSUED || m_axis_tuser == KIND_FULL ||
      m_axis_tuser == KIND_RETX || m_axis_tuser == KIND_TIMED_OUT)
      |-> m_axis_tdata[SEQ_W-1:0] != '0)
    else $error("drawn or stored sequence id is zero");

  a_noctl_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_NOT_CTRL)
      |-> (m_axis_tdata[SEQ_W-1:0] == '0) && m_axis_tlast)
    else $error("rejected issue carries a sequence id or is not final");

endmodule

bind acmp_inflight_command_tracker_top acit_port_checker u_acit_checker (.*);
